// ----- rtl/radar_frame_parser_unit_macros.svh -----
// assertion macros for the radar frame parser
`ifndef RADAR_FRAME_PARSER_UNIT_MACROS_SVH
`define RADAR_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define RFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define RFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rfp_pkg.sv -----
package rfp_pkg;

	// frame delimiters and the fall pattern
	localparam logic [7:0] HDR0      = 8'h53;
	localparam logic [7:0] HDR1      = 8'h59;
	localparam logic [7:0] TAIL0     = 8'h54;
	localparam logic [7:0] TAIL1     = 8'h43;
	localparam logic [7:0] FALL_CTRL = 8'h83;
	localparam logic [7:0] FALL_CMD  = 8'h01;
	localparam logic [7:0] FALL_DATA = 8'h01;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CSUM    = 2'd1,
		ST_TAIL    = 2'd2,
		ST_CUT_OFF = 2'd3
	} status_t;

	// parser phase
	typedef enum logic [3:0] {
		PH_HUNT0 = 4'd0,
		PH_HUNT1 = 4'd1,
		PH_CTRL  = 4'd2,
		PH_CMD   = 4'd3,
		PH_LENH  = 4'd4,
		PH_LENL  = 4'd5,
		PH_DATA  = 4'd6,
		PH_CSUM  = 4'd7,
		PH_TAIL0 = 4'd8,
		PH_TAIL1 = 4'd9
	} phase_t;

	// packed result payload, lowest field last
	typedef struct packed {
		logic       fall_alarm;
		logic [7:0] first_data_byte;
		logic [15:0] data_length;
		logic [7:0] command_code;
		logic [7:0] control_code;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- rtl/radar_frame_parser_unit.sv -----
// a byte passes the input register, then the result register, which holds its result (if any)
// throughput: one byte per cycle while the result side takes transactions
// the input register and the result register part the two sides, so a waiting
// result does not stop intake until the input register also fills
// reset (arst_n low) empties both registers and returns the parser to header hunting
module radar_frame_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // in_byte
	input  logic                         s_tlast,  // last_in_buffer
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// control_code, command_code, data_length, first_data_byte, fall_alarm, zero fill
	output logic [rfp_pkg::TDATA_W-1:0]  m_tdata,
	output logic [1:0]                   m_tuser   // frame_status
);
	import rfp_pkg::*;

	`include "radar_frame_parser_unit_macros.svh"

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic       valid_s2;
	status_t    status_s2;
	result_t    result_s2;

	// parser state
	phase_t      phase_q;
	logic [7:0]  sum_q;
	logic [15:0] left_q;
	logic [15:0] len_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  cmd_q;
	logic [7:0]  first_q;
	logic        csum_ok_q;

	// next parser state
	phase_t      phase_d;
	logic [7:0]  sum_d;
	logic [15:0] left_d;
	logic [15:0] len_d;
	logic [7:0]  ctrl_d;
	logic [7:0]  cmd_d;
	logic [7:0]  first_d;
	logic        csum_ok_d;

	// per-byte outcome
	logic        emit;
	status_t     emit_status;
	logic        in_frame_d;
	logic        advance;
	logic [15:0] left_dec;

	// the input register moves on when the result register can take its outcome
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign left_dec = left_q - 16'd1;

	// phase step for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		left_d    = left_q;
		len_d     = len_q;
		ctrl_d    = ctrl_q;
		cmd_d     = cmd_q;
		first_d   = first_q;
		csum_ok_d = csum_ok_q;
		unique case (phase_q)
			PH_HUNT0: begin
				if (byte_s1 == HDR0) phase_d = PH_HUNT1;
			end
			PH_HUNT1: begin
				if (byte_s1 == HDR1) begin
					phase_d   = PH_CTRL;
					sum_d     = HDR0 + HDR1;
					left_d    = '0;
					len_d     = '0;
					ctrl_d    = '0;
					cmd_d     = '0;
					first_d   = '0;
					csum_ok_d = 1'b0;
				end else if (byte_s1 != HDR0) begin
					phase_d = PH_HUNT0;
				end
			end
			PH_CTRL: begin
				ctrl_d  = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_LENH;
			end
			PH_LENH: begin
				len_d   = {byte_s1, 8'd0};
				sum_d   = sum_q + byte_s1;
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				len_d   = {len_q[15:8], byte_s1};
				left_d  = {len_q[15:8], byte_s1};
				sum_d   = sum_q + byte_s1;
				phase_d = ({len_q[15:8], byte_s1} == 16'd0) ? PH_CSUM : PH_DATA;
			end
			PH_DATA: begin
				if (left_q == len_q) first_d = byte_s1;
				sum_d  = sum_q + byte_s1;
				left_d = left_dec;
				if (left_dec == 16'd0) phase_d = PH_CSUM;
			end
			PH_CSUM: begin
				csum_ok_d = (byte_s1 == sum_q);
				phase_d   = PH_TAIL0;
			end
			PH_TAIL0: begin
				phase_d = (byte_s1 == TAIL0) ? PH_TAIL1 : PH_HUNT0;
			end
			PH_TAIL1: begin
				phase_d = PH_HUNT0;
			end
			default: begin
				phase_d = PH_HUNT0;
			end
		endcase
	end

	// result decision for the byte in the input register
	assign in_frame_d = (phase_d != PH_HUNT0) && (phase_d != PH_HUNT1);

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		priority if (phase_q == PH_TAIL0 && byte_s1 != TAIL0) begin
			emit        = 1'b1;
			emit_status = ST_TAIL;
		end else if (phase_q == PH_TAIL1) begin
			emit = 1'b1;
			if (byte_s1 != TAIL1) emit_status = ST_TAIL;
			else if (!csum_ok_q)  emit_status = ST_CSUM;
			else                  emit_status = ST_OK;
		end else if (last_s1 && in_frame_d) begin
			emit        = 1'b1;
			emit_status = ST_CUT_OFF;
		end else begin
			emit = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parser state, back to reset values after a buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT0;
			sum_q     <= '0;
			left_q    <= '0;
			len_q     <= '0;
			ctrl_q    <= '0;
			cmd_q     <= '0;
			first_q   <= '0;
			csum_ok_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q   <= PH_HUNT0;
				sum_q     <= '0;
				left_q    <= '0;
				len_q     <= '0;
				ctrl_q    <= '0;
				cmd_q     <= '0;
				first_q   <= '0;
				csum_ok_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				sum_q     <= sum_d;
				left_q    <= left_d;
				len_q     <= len_d;
				ctrl_q    <= ctrl_d;
				cmd_q     <= cmd_d;
				first_q   <= first_d;
				csum_ok_q <= csum_ok_d;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload, fields as left by this byte
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_s2                 <= emit_status;
			result_s2.control_code    <= ctrl_d;
			result_s2.command_code    <= cmd_d;
			result_s2.data_length     <= len_d;
			result_s2.first_data_byte <= first_d;
			result_s2.fall_alarm      <= (emit_status == ST_OK) && (ctrl_d == FALL_CTRL) &&
				(cmd_d == FALL_CMD) && (len_d != 16'd0) && (first_d == FALL_DATA);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, result_s2};

	// checks
	`RFP_ASSERT_NOW(a_alarm_only_ok, m_tvalid && result_s2.fall_alarm, status_s2 == ST_OK,
		"fall alarm on a frame that is not ok")
	`RFP_ASSERT_NEXT(a_buffer_end_resets, advance && last_s1,
		phase_q == PH_HUNT0 && sum_q == 8'd0 && !csum_ok_q,
		"parser not back in hunting after buffer end")
	`RFP_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(byte_s1),
		"held input byte lost while result side stalled")

endmodule
